### design/srgt_pkg.sv
// Package for the Sobel RGB edge filter: widths, register codes, gray weights and helpers.
package srgt_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 13;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [COL_W-1:0] WIDTH_RESET     = COL_W'(640);
    localparam logic [ROW_W-1:0] HEIGHT_RESET    = ROW_W'(480);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(160);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } cfg_index_t;

    // Gray weights 30, 59 and 11 premultiplied by the reciprocal of 100 (5243 / 2^19),
    // which gives the exact floor for every weighted sum up to 25500.
    localparam int GRAY_SHIFT  = 19;
    localparam int GRAY_ACC_W  = 27;
    localparam int GRAY_K_RED  = 157290;
    localparam int GRAY_K_GRN  = 309337;
    localparam int GRAY_K_BLU  = 57673;

    function automatic logic [CH_W-1:0] sobel_channel(
        input logic [CH_W-1:0] lt,
        input logic [CH_W-1:0] lm,
        input logic [CH_W-1:0] lb,
        input logic [CH_W-1:0] rt,
        input logic [CH_W-1:0] rm,
        input logic [CH_W-1:0] rb,
        input logic            left_ok
    );
        logic [CH_W+1:0]        l_sum;
        logic [CH_W+1:0]        r_sum;
        logic signed [CH_W+3:0] s;
        l_sum = {2'b00, lt} + {1'b0, lm, 1'b0} + {2'b00, lb};
        r_sum = {2'b00, rt} + {1'b0, rm, 1'b0} + {2'b00, rb};
        if (left_ok)
        begin
            s = $signed({2'b00, l_sum}) - $signed({2'b00, r_sum});
        end
        else
        begin
            s = -$signed({2'b00, r_sum});
        end
        if (s < 0)
        begin
            return '0;
        end
        else if (s > $signed((CH_W+4)'(255)))
        begin
            return CH_W'(255);
        end
        else
        begin
            return s[CH_W-1:0];
        end
    endfunction

endpackage

### design/srgt_ifs.sv
// Stream interfaces for pixel beats in and edge result beats out.
interface srgt_pixel_if;
    import srgt_pkg::*;

    logic            valid;
    logic            ready;
    logic            action;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output action, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input action, input red, input green, input blue,
                    output ready);
endinterface

interface srgt_result_if;
    import srgt_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] gray_edge;
    logic            is_edge;
    logic            row_end;
    logic            image_end;

    modport source (output valid, output gray_edge, output is_edge, output row_end,
                    output image_end, input ready);
    modport sink   (input valid, input gray_edge, input is_edge, input row_end,
                    input image_end, output ready);
endinterface

### design/sobel_rgb_gray_threshold.sv
// Sobel RGB edge filter with gray conversion and threshold, top level.
//
// The block takes one pixel beat per clock and, with the result side ready, keeps that
// rate indefinitely. Each image row is sent as image_width pixels plus one flush beat,
// and one flush row follows the image; the result for pixel (r,c) leaves with the beat
// at row r+1, column c+1. A beat is accepted into an input stage, where the two line
// buffers (MAX_WIDTH x 24 bits each, one read when the beat is accepted and one write
// when it leaves) supply the upper rows; when the beat leaves, the filtered, gray-converted
// result moves into the output register, which holds it until the result side is ready.
// The output register lets a new beat enter while a finished result waits. The line
// buffers need no clearing pass after reset. Configuration is taken on any cycle and
// must only be changed while no beat is in flight.
module sobel_rgb_gray_threshold #(
    parameter int MAX_WIDTH = srgt_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [srgt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srgt_pkg::CFG_DATA_W-1:0] cfg_data,
    srgt_pixel_if.sink                      pixel,
    srgt_result_if.source                   result
);
    import srgt_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WCMP_W = (COL_W > AW + 1) ? COL_W : AW + 1;

    logic [COL_W-1:0] image_width_reg;
    logic [ROW_W-1:0] image_height_reg;
    logic [THR_W-1:0] edge_threshold_reg;

    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;

    logic [WCMP_W-1:0] width_ext, width_eff, col_ext;
    logic [ROW_W-1:0]  height_eff;
    logic              flush_col, last_row, accept, advance;
    logic [PIX_W-1:0]  px_in;
    logic [AW-1:0]     rd_addr;

    logic             in_vld_reg, in_vld_next;
    logic [PIX_W-1:0] px_reg;
    logic             flush_reg, last_row_reg, emit_reg, left_ok_reg, top_zero_reg;
    logic [AW-1:0]    addr_reg;
    logic [PIX_W-1:0] top_rd_reg, mid_rd_reg;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic [2:0][PIX_W-1:0] win_a_reg, win_b_reg, col_new;
    logic [2:0][CH_W-1:0]  ch_val;
    logic [GRAY_ACC_W-1:0] gray_acc;
    logic [CH_W-1:0]       gray;

    logic            out_vld_reg, out_vld_next;
    logic [CH_W-1:0] gray_reg;
    logic            is_edge_reg, row_end_reg, image_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= WIDTH_RESET;
            image_height_reg   <= HEIGHT_RESET;
            edge_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[COL_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[ROW_W-1:0];
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        width_ext = WCMP_W'(image_width_reg);
        col_ext   = WCMP_W'(col_cnt_reg);
        if (width_ext == '0)
        begin
            width_eff = WCMP_W'(1);
        end
        else if (width_ext > WCMP_W'(MAX_WIDTH))
        begin
            width_eff = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        height_eff = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;
        flush_col  = (col_ext >= width_eff);
        last_row   = (row_cnt_reg >= height_eff);
        rd_addr    = AW'(col_cnt_reg);
        px_in      = pixel.action ? '0 : {pixel.red, pixel.green, pixel.blue};
    end

    assign advance      = in_vld_reg && (!emit_reg || !out_vld_reg || result.ready);
    assign pixel.ready  = !in_vld_reg || advance;
    assign accept       = pixel.valid && pixel.ready;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (flush_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
        if (advance && emit_reg)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            win_a_reg   <= '0;
            win_b_reg   <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                win_b_reg <= win_a_reg;
                win_a_reg <= col_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg       <= px_in;
            flush_reg    <= flush_col;
            last_row_reg <= last_row;
            emit_reg     <= (row_cnt_reg != '0) && (col_cnt_reg != '0);
            left_ok_reg  <= (col_cnt_reg >= COL_W'(2));
            top_zero_reg <= (row_cnt_reg < ROW_W'(2));
            addr_reg     <= rd_addr;
        end
    end

    // The beat that reads an entry always leaves before the next beat at that column
    // arrives, so the line buffers need no bypass.
    always_ff @(posedge clk)
    begin
        if (accept && !flush_col)
        begin
            top_rd_reg <= upper_mem[rd_addr];
            mid_rd_reg <= lower_mem[rd_addr];
        end
        if (advance && !flush_reg)
        begin
            upper_mem[addr_reg] <= mid_rd_reg;
            lower_mem[addr_reg] <= px_reg;
        end
    end

    always_comb
    begin
        col_new[0] = (flush_reg || top_zero_reg) ? '0 : top_rd_reg;
        col_new[1] = flush_reg ? '0 : mid_rd_reg;
        col_new[2] = (flush_reg || last_row_reg) ? '0 : px_reg;
        for (int k = 0; k < 3; k++)
        begin
            ch_val[k] = sobel_channel(win_b_reg[0][PIX_W-1-CH_W*k -: CH_W],
                                      win_b_reg[1][PIX_W-1-CH_W*k -: CH_W],
                                      win_b_reg[2][PIX_W-1-CH_W*k -: CH_W],
                                      col_new[0][PIX_W-1-CH_W*k -: CH_W],
                                      col_new[1][PIX_W-1-CH_W*k -: CH_W],
                                      col_new[2][PIX_W-1-CH_W*k -: CH_W],
                                      left_ok_reg);
        end
        gray_acc = GRAY_ACC_W'(ch_val[0]) * GRAY_ACC_W'(GRAY_K_RED)
                 + GRAY_ACC_W'(ch_val[1]) * GRAY_ACC_W'(GRAY_K_GRN)
                 + GRAY_ACC_W'(ch_val[2]) * GRAY_ACC_W'(GRAY_K_BLU);
        gray     = gray_acc[GRAY_SHIFT +: CH_W];
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit_reg)
        begin
            gray_reg      <= gray;
            is_edge_reg   <= (gray > edge_threshold_reg);
            row_end_reg   <= flush_reg;
            image_end_reg <= flush_reg && last_row_reg;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.gray_edge = gray_reg;
    assign result.is_edge   = is_edge_reg;
    assign result.row_end   = row_end_reg;
    assign result.image_end = image_end_reg;

endmodule

### design/srgt_checker.sv
// Port-level assertions for the Sobel RGB edge filter and their binding to the top level.
module srgt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pix_valid,
    input logic                            pix_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [srgt_pkg::CH_W-1:0]       res_gray_edge,
    input logic                            res_is_edge,
    input logic                            res_row_end,
    input logic                            res_image_end
);
    import srgt_pkg::*;

    // A result beat that waits is neither withdrawn nor changed.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_gray_edge)
            && $stable(res_is_edge) && $stable(res_row_end) && $stable(res_image_end))
        else $error("result beat changed while stalled");

    // With the result side ready, the input side never stalls.
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> pix_ready)
        else $error("input stalled while result side was ready");

    // A new result beat comes from an earlier accepted pixel beat.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
        else $error("result beat without matching pixel beat");

endmodule

bind sobel_rgb_gray_threshold srgt_checker u_srgt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_valid     (pixel.valid),
    .pix_ready     (pixel.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_gray_edge (result.gray_edge),
    .res_is_edge   (result.is_edge),
    .res_row_end   (result.row_end),
    .res_image_end (result.image_end)
);

### tb/sobel_rgb_gray_threshold_test.sv
// Testbench for the Sobel RGB edge filter: random pixel streams against a line-buffer predictor.
module sobel_rgb_gray_threshold_test;
    import srgt_pkg::*;

    localparam int BEAT_BUDGET    = 1600;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 160;
    localparam int LINE_DEPTH     = MAX_WIDTH_DEFAULT;

    typedef struct {
        logic            action;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_beat_t;

    typedef struct packed {
        logic [CH_W-1:0] gray_edge;
        logic            is_edge;
        logic            row_end;
        logic            image_end;
    } edge_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srgt_pixel_if  pixel_bus ();
    srgt_result_if result_bus ();

    sobel_rgb_gray_threshold uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_bus),
        .result    (result_bus)
    );

    pixel_beat_t  pending_beats[$];
    edge_result_t expected_edges[$];
    pixel_beat_t  accepted;
    edge_result_t want;

    logic [PIX_W-1:0] upper_rows [LINE_DEPTH];
    logic [PIX_W-1:0] lower_rows [LINE_DEPTH];
    logic [PIX_W-1:0] window [3][3];
    int unsigned      column_pos;
    int unsigned      row_pos;
    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [THR_W-1:0] threshold_reg;

    int gen_col;
    int gen_row;
    bit beat_offered;
    int burst_left;
    int send_gap;
    bit holdoff_request;
    int holdoff_left;
    int stall_mode;
    int stall_phase_left;
    int idle_cycles;
    int error_count;
    int beats_queued;
    int results_checked;
    int images_closed;
    int register_writes;

    always
    begin
        #6 clk = ~clk;
    end

    function automatic int active_width();
        int w;
        w = int'(width_reg);
        if (w == 0)
        begin
            w = 1;
        end
        if (w > LINE_DEPTH)
        begin
            w = LINE_DEPTH;
        end
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = int'(height_reg);
        if (h == 0)
        begin
            h = 1;
        end
        return h;
    endfunction

    function automatic int channel_of(input logic [PIX_W-1:0] p, input int k);
        return int'(p[PIX_W-1-CH_W*k -: CH_W]);
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    task automatic filter_pixel_beat(input pixel_beat_t beat);
        int               w;
        int               h;
        int               k;
        int               s;
        int               gray;
        int               level [3];
        bit               flush_col;
        bit               last_row;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        edge_result_t     res;
        w = active_width();
        h = active_height();
        flush_col = column_pos >= w;
        last_row = row_pos >= h;
        px = beat.action ? '0 : {beat.red, beat.green, beat.blue};
        top = '0;
        mid = '0;
        bot = '0;
        if (!flush_col)
        begin
            top = upper_rows[column_pos];
            mid = lower_rows[column_pos];
            upper_rows[column_pos] = mid;
            lower_rows[column_pos] = px;
            bot = px;
            if (row_pos < 2)
            begin
                top = '0;
            end
            if (last_row)
            begin
                bot = '0;
            end
        end
        for (k = 0; k < 3; k++)
        begin
            window[k][0] = window[k][1];
            window[k][1] = window[k][2];
        end
        window[0][2] = top;
        window[1][2] = mid;
        window[2][2] = bot;
        if (row_pos >= 1 && column_pos >= 1)
        begin
            for (k = 0; k < 3; k++)
            begin
                s = 0;
                if (column_pos >= 2)
                begin
                    s = channel_of(window[0][0], k) + 2 * channel_of(window[1][0], k)
                        + channel_of(window[2][0], k);
                end
                s -= channel_of(window[0][2], k) + 2 * channel_of(window[1][2], k)
                     + channel_of(window[2][2], k);
                level[k] = (s < 0) ? 0 : ((s > 255) ? 255 : s);
            end
            gray = (30 * level[0] + 59 * level[1] + 11 * level[2]) / 100;
            res.gray_edge = CH_W'(gray);
            res.is_edge = gray > int'(threshold_reg);
            res.row_end = flush_col;
            res.image_end = flush_col && last_row;
            expected_edges.push_back(res);
        end
        if (flush_col)
        begin
            column_pos = 0;
            row_pos = last_row ? 0 : (row_pos + 1) % (1 << ROW_W);
        end
        else
        begin
            column_pos = (column_pos + 1) % (1 << COL_W);
        end
    endtask

    task automatic write_register(input cfg_index_t index, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_IMAGE_WIDTH:    width_reg = value[COL_W-1:0];
            CFG_IMAGE_HEIGHT:   height_reg = value[ROW_W-1:0];
            CFG_EDGE_THRESHOLD: threshold_reg = value[THR_W-1:0];
            default:            ;
        endcase
        register_writes++;
    endtask

    task automatic configure(input int w, input int h, input int thr);
        write_register(CFG_IMAGE_WIDTH, {2'($urandom), COL_W'(w)});
        write_register(CFG_IMAGE_HEIGHT, ROW_W'(h));
        write_register(CFG_EDGE_THRESHOLD, {5'($urandom), THR_W'(thr)});
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || beat_offered || expected_edges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_beat(input logic action, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                             output bit image_done);
        int          w;
        int          h;
        pixel_beat_t beat;
        w = active_width();
        h = active_height();
        beat.action = action;
        beat.red = r;
        beat.green = g;
        beat.blue = b;
        pending_beats.push_back(beat);
        beats_queued++;
        image_done = 1'b0;
        if (gen_col >= w)
        begin
            gen_col = 0;
            if (gen_row >= h)
            begin
                gen_row = 0;
                image_done = 1'b1;
            end
            else
            begin
                gen_row++;
            end
        end
        else
        begin
            gen_col++;
        end
    endtask

    task automatic queue_stream(input int max_beats, input bit to_image_end, input bit noisy);
        int n;
        bit done;
        for (n = 0; n < max_beats; n++)
        begin
            if (gen_col < active_width() && gen_row < active_height())
            begin
                push_beat(noisy && $urandom_range(0, 7) == 0, pick_channel(), pick_channel(),
                          pick_channel(), done);
            end
            else if (noisy)
            begin
                push_beat(1'($urandom_range(0, 1)), CH_W'($urandom), CH_W'($urandom),
                          CH_W'($urandom), done);
            end
            else
            begin
                push_beat(1'b1, '0, '0, '0, done);
            end
            if (done && to_image_end)
            begin
                break;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && !beat_offered)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                pixel_bus.valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                pixel_bus.valid <= 1'b1;
                pixel_bus.action <= pending_beats[0].action;
                pixel_bus.red <= pending_beats[0].red;
                pixel_bus.green <= pending_beats[0].green;
                pixel_bus.blue <= pending_beats[0].blue;
                beat_offered = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 32);
                    send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                pixel_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (stall_phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_phase_left = $urandom_range(16, 96);
            end
            else
            begin
                stall_phase_left--;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: result_bus.ready <= 1'b1;
                    1: result_bus.ready <= $urandom_range(0, 3) != 0;
                    2: result_bus.ready <= 1'($urandom_range(0, 1));
                    default: result_bus.ready <= (stall_phase_left % 3) != 0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                accepted.action = pixel_bus.action;
                accepted.red = pixel_bus.red;
                accepted.green = pixel_bus.green;
                accepted.blue = pixel_bus.blue;
                filter_pixel_beat(accepted);
                void'(pending_beats.pop_front());
                beat_offered = 1'b0;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_edges.size() == 0)
                begin
                    $error("result beat with nothing expected: gray_edge %0d",
                           result_bus.gray_edge);
                    error_count++;
                end
                else
                begin
                    want = expected_edges.pop_front();
                    results_checked++;
                    if (result_bus.gray_edge !== want.gray_edge)
                    begin
                        $error("gray_edge: expected %0d, actual %0d",
                               want.gray_edge, result_bus.gray_edge);
                        error_count++;
                    end
                    if (result_bus.is_edge !== want.is_edge)
                    begin
                        $error("is_edge: expected %0b, actual %0b",
                               want.is_edge, result_bus.is_edge);
                        error_count++;
                    end
                    if (result_bus.row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0b, actual %0b",
                               want.row_end, result_bus.row_end);
                        error_count++;
                    end
                    if (result_bus.image_end !== want.image_end)
                    begin
                        $error("image_end: expected %0b, actual %0b",
                               want.image_end, result_bus.image_end);
                        error_count++;
                    end
                    if (want.image_end)
                    begin
                        images_closed++;
                    end
                end
            end
            if ((pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no beat moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int w;
        int h;
        int thr;
        bit noisy;
        bit done;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        pixel_bus.valid = 1'b0;
        pixel_bus.action = 1'b0;
        pixel_bus.red = '0;
        pixel_bus.green = '0;
        pixel_bus.blue = '0;
        result_bus.ready = 1'b0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        threshold_reg = THRESHOLD_RESET;
        foreach (upper_rows[i])
        begin
            upper_rows[i] = '0;
            lower_rows[i] = '0;
        end
        foreach (window[i, j])
        begin
            window[i][j] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A row started at the reset size is cut short by shrinking the width and height.
        queue_stream(8, 1'b0, 1'b0);
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_register(CFG_IMAGE_HEIGHT, '0);
        queue_stream(100, 1'b1, 1'b0);
        wait_idle();

        configure(2, 2, 0);
        push_beat(1'b0, '1, '1, '1, done);
        push_beat(1'b0, '0, '0, '0, done);
        push_beat(1'b1, '0, '0, '0, done);
        push_beat(1'b0, '0, '1, '0, done);
        push_beat(1'b1, '1, '0, '1, done);
        push_beat(1'b0, '1, '1, '1, done);
        queue_stream(3, 1'b1, 1'b0);
        wait_idle();

        configure(0, 1, 255);
        push_beat(1'b0, '1, '1, '1, done);
        queue_stream(3, 1'b1, 1'b0);
        wait_idle();

        // A width above the line buffer depth is held at the depth for one full row.
        configure((1 << COL_W) - 1, 1, $urandom_range(0, 255));
        queue_stream(LINE_DEPTH + 7, 1'b0, 1'b0);
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        queue_stream(1 << 20, 1'b1, 1'b0);
        wait_idle();

        w = $urandom_range(1, 6);
        configure(w, $urandom_range(4096, 8191), $urandom_range(0, 255));
        queue_stream(3 * (w + 1) + $urandom_range(0, w), 1'b0, 1'b0);
        wait_idle();
        write_register(CFG_IMAGE_HEIGHT, ROW_W'($urandom_range(0, 3)));
        queue_stream(1 << 20, 1'b1, 1'b0);
        wait_idle();

        configure(24, 5, $urandom_range(0, 255));
        holdoff_request = 1'b1;
        queue_stream(1 << 20, 1'b1, 1'b0);

        while (beats_queued < BEAT_BUDGET)
        begin
            wait_idle();
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            h = $urandom_range(0, 6);
            if ($urandom_range(0, 5) == 0)
            begin
                thr = $urandom_range(0, 1) ? 255 : 0;
            end
            else
            begin
                thr = $urandom_range(0, 255);
            end
            configure(w, h, thr);
            noisy = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 3) == 0)
            begin
                queue_stream($urandom_range(1, (w + 1) * (h + 1)), 1'b0, noisy);
                wait_idle();
                if ($urandom_range(0, 1))
                begin
                    write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, w)));
                end
                else
                begin
                    write_register(CFG_IMAGE_HEIGHT, ROW_W'($urandom_range(0, 8)));
                end
            end
            repeat ($urandom_range(1, 3)) queue_stream(1 << 20, 1'b1, noisy);
        end

        wait_idle();
        $display("Run covered %0d pixel beats and %0d checked results over %0d images,",
                 beats_queued, results_checked, images_closed);
        $display("with %0d register writes, mid-image resizes, flush noise and output stalls.",
                 register_writes);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
